// ===== rtl/core/console_escape_interpreter_defines.svh =====
// Assertion macros shared by the console escape interpreter RTL.
`ifndef CONSOLE_ESCAPE_INTERPRETER_DEFINES_SVH
`define CONSOLE_ESCAPE_INTERPRETER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CEI_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CEI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/cei_pkg.sv =====
// Types and constants for the console escape interpreter.
package cei_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CODE_POS        = 8'h10;
	localparam logic [7:0] CODE_ATTR       = 8'h1D;
	localparam logic [7:0] CODE_FF         = 8'h0C;
	localparam logic [7:0] PRINT_MASK      = 8'hE0;
	localparam logic [7:0] ATTR_SHORT_LO   = 8'h60;
	localparam logic [7:0] ATTR_SHORT_HI   = 8'h70;
	localparam logic [7:0] POS_ROW_LO      = 8'd32;
	localparam logic [7:0] POS_ROW_HI      = 8'd56;
	localparam logic [7:0] POS_COL_LO      = 8'd32;
	localparam logic [7:0] POS_COL_HI      = 8'd111;
	localparam logic [7:0] ATTR_RESET      = 8'h07;

	typedef enum logic [1:0] {
		CMD_PRINT = 2'd0,
		CMD_RAW   = 2'd1,
		CMD_CURS  = 2'd2,
		CMD_CLS   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'd0,
		SEQ_ONE  = 2'd1,
		SEQ_TWO  = 2'd2
	} seq_t;

	// One queued command; pair marks form feed (home cursor, then clear).
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] char_code;
		logic [7:0] attr;
		logic [4:0] row;
		logic [6:0] col;
		logic       pair;
	} entry_t;

endpackage

// ===== rtl/core/cei_front.sv =====
// Front end: accepts bytes, tracks escape sequences and attribute, emits commands.
module cei_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic            cfg_wr_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      out_byte,
	input  logic            q_full,
	output logic            push,
	output cei_pkg::entry_t push_entry
);

	cei_pkg::seq_t seq_q, seq_d;
	logic          is_attr_q, is_attr_d;
	logic [7:0]    second_q, second_d;
	logic [7:0]    attr_q, attr_d;
	logic          colour_q;
	logic          accept;
	logic [7:0]    sec;
	logic [7:0]    raw_attr;
	logic [7:0]    new_attr;
	logic          short_seq;
	logic          pos_ok;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign sec = (seq_q == cei_pkg::SEQ_ONE) ? out_byte : second_q;
	assign short_seq = is_attr_q && (out_byte >= cei_pkg::ATTR_SHORT_LO)
		&& (out_byte <= cei_pkg::ATTR_SHORT_HI);
	assign pos_ok = (second_q >= cei_pkg::POS_ROW_LO) && (second_q <= cei_pkg::POS_ROW_HI)
		&& (out_byte >= cei_pkg::POS_COL_LO) && (out_byte <= cei_pkg::POS_COL_HI);

	// Second byte 0x60 and up sets foreground only; below it sets both nibbles.
	assign raw_attr = (sec >= cei_pkg::ATTR_SHORT_LO) ? {attr_q[7:4], sec[3:0]}
		: {sec[3:0], out_byte[3:0]};
	// Mono fold keeps blink and intensity, forces normal or reverse video.
	assign new_attr = colour_q ? raw_attr
		: {raw_attr[7], {3{raw_attr[2:0] == 3'd0}}, raw_attr[3],
		   {3{raw_attr[2:0] != 3'd0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= cei_pkg::SEQ_IDLE;
			is_attr_q <= 1'b0;
			second_q  <= '0;
			attr_q    <= cei_pkg::ATTR_RESET;
			colour_q  <= 1'b0;
		end else begin
			seq_q     <= seq_d;
			is_attr_q <= is_attr_d;
			second_q  <= second_d;
			attr_q    <= attr_d;
			if (cfg_wr_en) begin
				colour_q <= cfg_wr_data;
			end
		end
	end

	always_comb begin
		seq_d      = seq_q;
		is_attr_d  = is_attr_q;
		second_d   = second_q;
		attr_d     = attr_q;
		push       = 1'b0;
		push_entry = '0;
		if (accept) begin
			unique case (seq_q)
				cei_pkg::SEQ_IDLE: begin
					if ((out_byte & cei_pkg::PRINT_MASK) != 8'd0) begin
						push                 = 1'b1;
						push_entry.cmd       = cei_pkg::CMD_PRINT;
						push_entry.char_code = out_byte;
						push_entry.attr      = attr_q;
					end else if (out_byte == cei_pkg::CODE_FF) begin
						push            = 1'b1;
						push_entry.cmd  = cei_pkg::CMD_CLS;
						push_entry.attr = attr_q;
						push_entry.pair = 1'b1;
					end else if (out_byte == cei_pkg::CODE_POS
						|| out_byte == cei_pkg::CODE_ATTR) begin
						seq_d     = cei_pkg::SEQ_ONE;
						is_attr_d = (out_byte == cei_pkg::CODE_ATTR);
					end else begin
						push                 = 1'b1;
						push_entry.cmd       = cei_pkg::CMD_RAW;
						push_entry.char_code = out_byte;
					end
				end
				cei_pkg::SEQ_ONE: begin
					second_d = out_byte;
					if (short_seq) begin
						seq_d  = cei_pkg::SEQ_IDLE;
						attr_d = new_attr;
					end else begin
						seq_d = cei_pkg::SEQ_TWO;
					end
				end
				cei_pkg::SEQ_TWO: begin
					seq_d = cei_pkg::SEQ_IDLE;
					if (is_attr_q) begin
						attr_d = new_attr;
					end else if (pos_ok) begin
						push           = 1'b1;
						push_entry.cmd = cei_pkg::CMD_CURS;
						push_entry.row = 5'(second_q - cei_pkg::POS_ROW_LO);
						push_entry.col = 7'(out_byte - cei_pkg::POS_COL_LO);
					end
				end
				default: begin
					seq_d = cei_pkg::SEQ_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/cei_queue.sv =====
// Command queue between the front end and the output stage.
`include "console_escape_interpreter_defines.svh"

module cei_queue #(
	parameter int DEPTH = cei_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cei_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output cei_pkg::entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cei_pkg::entry_t  slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`CEI_ASSERT_HOLDS(a_no_push_full, push, !full || pop, "push into full queue")
	`CEI_ASSERT_HOLDS(a_no_pop_empty, pop, not_empty, "pop from empty queue")
	`CEI_ASSERT_NEXT(a_count_grows, push && !pop, count_q == $past(count_q) + CNT_W'(1), "count did not grow")

endmodule

// ===== rtl/core/cei_back.sv =====
// Output stage: drains queued commands into the result register, splitting form feed.
`include "console_escape_interpreter_defines.svh"

module cei_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            not_empty,
	input  cei_pkg::entry_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      command,
	output logic [7:0]      char_code,
	output logic [7:0]      attribute,
	output logic [4:0]      cursor_row,
	output logic [6:0]      cursor_col,
	output logic            last
);

	logic         out_valid_q;
	cei_pkg::cmd_t command_q;
	logic [7:0]   char_code_q;
	logic [7:0]   attribute_q;
	logic [4:0]   cursor_row_q;
	logic [6:0]   cursor_col_q;
	logic         last_q;
	logic         phase_q;
	logic         load;
	logic         first_half;

	assign load       = not_empty && (!out_valid_q || !out_stall);
	assign first_half = head.pair && !phase_q;
	// Hold a form feed entry until its second command is loaded.
	assign pop        = load && !first_half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			phase_q     <= first_half;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (first_half) begin
				command_q    <= cei_pkg::CMD_CURS;
				char_code_q  <= '0;
				attribute_q  <= '0;
				cursor_row_q <= '0;
				cursor_col_q <= '0;
				last_q       <= 1'b0;
			end else begin
				command_q    <= head.cmd;
				char_code_q  <= head.char_code;
				attribute_q  <= head.attr;
				cursor_row_q <= head.row;
				cursor_col_q <= head.col;
				last_q       <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign command    = command_q;
	assign char_code  = char_code_q;
	assign attribute  = attribute_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;
	assign last       = last_q;

	`CEI_ASSERT_HOLDS(a_phase_shows_home, phase_q, out_valid_q && command_q == cei_pkg::CMD_CURS && !last_q, "pending clear without home command shown")
	`CEI_ASSERT_HOLDS(a_not_last_is_ff, out_valid_q && !last_q, phase_q, "non-final result outside form feed")
	`CEI_ASSERT_HOLDS(a_pair_pop_second, pop && head.pair, phase_q, "form feed popped before home command")

endmodule

// ===== rtl/core/console_escape_interpreter.sv =====
// Top level of the console escape interpreter.
// Takes one console byte per cycle while in_stall is low and turns it into display
// commands: print, raw control byte, set cursor, clear screen. Each byte is
// classified by the front end, which holds the escape-sequence state and current
// attribute; commands then pass through a QUEUE_DEPTH-entry queue to a registered
// output stage, so a result is registered in a queue slot and then in the output
// register. Every byte gives at most one queued entry, except that form feed gives
// two results (home cursor, then clear) from one entry, held at the queue head until
// the clear is loaded; a long run of form feeds can therefore fill the queue, and
// in_stall is high only while the queue is full. colour_q resets to 0 (mono fold on).
module console_escape_interpreter #(
	parameter int QUEUE_DEPTH = cei_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] out_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] command,
	output logic [7:0] char_code,
	output logic [7:0] attribute,
	output logic [4:0] cursor_row,
	output logic [6:0] cursor_col,
	output logic       last
);

	logic            push;
	cei_pkg::entry_t push_entry;
	logic            q_full;
	logic            pop;
	logic            not_empty;
	cei_pkg::entry_t head;

	cei_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.out_byte   (out_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	cei_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	cei_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.command   (command),
		.char_code (char_code),
		.attribute (attribute),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.last      (last)
	);

endmodule
